// ===== design/lrcf_pkg.sv =====
package lrcf_pkg;

  localparam int CMD_BYTES = 14;
  localparam int CFG_IDX_W = 8;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_PIXEL  = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WS2812     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APA102_DAT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APA102_CLK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_ALL   = 8'd3;

  localparam logic [7:0] MAGIC_U = 8'h55;
  localparam logic [7:0] MAGIC_P = 8'h50;
  localparam logic [7:0] MAGIC_X = 8'h58;
  localparam logic [7:0] MAGIC_L = 8'h4c;
  localparam logic [7:0] WS2812_STRUCT_ID = 8'h03;
  localparam logic [7:0] DRAW_CHANNEL = 8'hff;
  localparam logic [4:0] BRI_MASK = 5'h1f;

  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] data;
    logic [3:0]                ndata;
    logic                      hdr;
    logic                      close;
  } lrcf_cmd_t;

  function automatic logic [31:0] nib_tab(input logic [3:0] n);
    logic [31:0] v;
    case (n)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h1db71064;
      4'h2: v = 32'h3b6e20c8;
      4'h3: v = 32'h26d930ac;
      4'h4: v = 32'h76dc4190;
      4'h5: v = 32'h6b6b51f4;
      4'h6: v = 32'h4db26158;
      4'h7: v = 32'h5005713c;
      4'h8: v = 32'hedb88320;
      4'h9: v = 32'hf00f9344;
      4'ha: v = 32'hd6d6a3e8;
      4'hb: v = 32'hcb61b38c;
      4'hc: v = 32'h9b64c2b0;
      4'hd: v = 32'h86d3d2d4;
      4'he: v = 32'ha00ae278;
      4'hf: v = 32'hbdbdf21c;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = nib_tab(c[3:0] ^ b[3:0]) ^ (c >> 4);
    t = nib_tab(t[3:0] ^ b[7:4]) ^ (t >> 4);
    return t;
  endfunction

endpackage

// ===== design/lrcf_front.sv =====
module lrcf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [lrcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             acc,
  input  logic [1:0]                       mode,
  input  logic [7:0]                       chan_no,
  input  logic [7:0]                       record_type,
  input  logic [7:0]                       order_byte,
  input  logic [15:0]                      pixel_count,
  input  logic [31:0]                      frequency,
  input  logic [7:0]                       brightness,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  output logic                             push,
  output lrcf_pkg::lrcf_cmd_t              cmd
);

  logic [7:0]  ws_code_r, apd_code_r, apc_code_r, draw_code_r;
  logic [15:0] pix_left_r, pix_left_nxt;
  logic        apa_act_r, apa_act_nxt;
  logic [4:0]  bri_r, bri_nxt;

  always_comb begin
    cmd          = '0;
    push         = 1'b0;
    pix_left_nxt = pix_left_r;
    apa_act_nxt  = apa_act_r;
    bri_nxt      = bri_r;
    case (mode)
      lrcf_pkg::MODE_RECORD: begin
        push         = 1'b1;
        cmd.hdr      = 1'b1;
        cmd.data[0]  = lrcf_pkg::MAGIC_U;
        cmd.data[1]  = lrcf_pkg::MAGIC_P;
        cmd.data[2]  = lrcf_pkg::MAGIC_X;
        cmd.data[3]  = lrcf_pkg::MAGIC_L;
        cmd.data[4]  = chan_no;
        cmd.data[5]  = record_type;
        cmd.ndata    = 4'd6;
        apa_act_nxt  = 1'b0;
        bri_nxt      = '0;
        pix_left_nxt = '0;
        if (record_type == ws_code_r) begin
          cmd.data[6]  = lrcf_pkg::WS2812_STRUCT_ID;
          cmd.data[7]  = order_byte;
          cmd.data[8]  = pixel_count[7:0];
          cmd.data[9]  = pixel_count[15:8];
          cmd.ndata    = 4'd10;
          pix_left_nxt = pixel_count;
        end else if (record_type == apd_code_r) begin
          cmd.data[6]  = frequency[7:0];
          cmd.data[7]  = frequency[15:8];
          cmd.data[8]  = frequency[23:16];
          cmd.data[9]  = frequency[31:24];
          cmd.data[10] = order_byte;
          cmd.data[11] = 8'h00;
          cmd.data[12] = pixel_count[7:0];
          cmd.data[13] = pixel_count[15:8];
          cmd.ndata    = 4'd14;
          pix_left_nxt = pixel_count;
          apa_act_nxt  = 1'b1;
          bri_nxt      = brightness[4:0] & lrcf_pkg::BRI_MASK;
        end else if (record_type == apc_code_r) begin
          cmd.data[6]  = frequency[7:0];
          cmd.data[7]  = frequency[15:8];
          cmd.data[8]  = frequency[23:16];
          cmd.data[9]  = frequency[31:24];
          cmd.ndata    = 4'd10;
        end
        cmd.close = (pix_left_nxt == 16'd0);
      end
      lrcf_pkg::MODE_PIXEL: begin
        if (pix_left_r != 16'd0) begin
          push         = 1'b1;
          cmd.data[0]  = red;
          cmd.data[1]  = green;
          cmd.data[2]  = blue;
          cmd.data[3]  = {3'b000, bri_r};
          cmd.ndata    = apa_act_r ? 4'd4 : 4'd3;
          cmd.close    = (pix_left_r == 16'd1);
          pix_left_nxt = pix_left_r - 16'd1;
        end
      end
      lrcf_pkg::MODE_DRAW: begin
        push         = 1'b1;
        cmd.hdr      = 1'b1;
        cmd.close    = 1'b1;
        cmd.data[0]  = lrcf_pkg::MAGIC_U;
        cmd.data[1]  = lrcf_pkg::MAGIC_P;
        cmd.data[2]  = lrcf_pkg::MAGIC_X;
        cmd.data[3]  = lrcf_pkg::MAGIC_L;
        cmd.data[4]  = lrcf_pkg::DRAW_CHANNEL;
        cmd.data[5]  = draw_code_r;
        cmd.ndata    = 4'd6;
        pix_left_nxt = '0;
        apa_act_nxt  = 1'b0;
        bri_nxt      = '0;
      end
      default: begin
      end
    endcase
    if (!acc) begin
      push         = 1'b0;
      pix_left_nxt = pix_left_r;
      apa_act_nxt  = apa_act_r;
      bri_nxt      = bri_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_code_r   <= 8'd1;
      apd_code_r  <= 8'd3;
      apc_code_r  <= 8'd4;
      draw_code_r <= 8'd2;
      pix_left_r  <= '0;
      apa_act_r   <= 1'b0;
      bri_r       <= '0;
    end else begin
      pix_left_r <= pix_left_nxt;
      apa_act_r  <= apa_act_nxt;
      bri_r      <= bri_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          lrcf_pkg::REG_WS2812:     ws_code_r   <= cfg_data;
          lrcf_pkg::REG_APA102_DAT: apd_code_r  <= cfg_data;
          lrcf_pkg::REG_APA102_CLK: apc_code_r  <= cfg_data;
          lrcf_pkg::REG_DRAW_ALL:   draw_code_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== design/lrcf_cmd_fifo.sv =====
module lrcf_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lrcf_pkg::lrcf_cmd_t  wr_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 rd_valid,
  output lrcf_pkg::lrcf_cmd_t  rd_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lrcf_pkg::lrcf_cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== design/lrcf_back.sv =====
module lrcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  lrcf_pkg::lrcf_cmd_t  cmd_in,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_run,
  output logic                 out_frame_end
);

  lrcf_pkg::lrcf_cmd_t cmd_r;
  logic        busy_r;
  logic [4:0]  idx_r;
  logic [31:0] crc_r, crc_nxt, crc_in, crc_fin;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        last_r, fe_r;

  logic        emit, is_data, is_last, is_fe;
  logic [4:0]  total, crc_k;
  logic [7:0]  cur_byte;

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_frame_end   = fe_r;

  always_comb begin
    total   = {1'b0, cmd_r.ndata} + (cmd_r.close ? 5'd4 : 5'd0);
    is_data = (idx_r < {1'b0, cmd_r.ndata});
    crc_k   = idx_r - {1'b0, cmd_r.ndata};
    crc_in  = (cmd_r.hdr && idx_r == 5'd0) ? lrcf_pkg::CRC_INIT : crc_r;
    crc_fin = crc_r ^ lrcf_pkg::CRC_INIT;
    is_last = (idx_r == total - 5'd1);
    is_fe   = !is_data && (crc_k[1:0] == 2'd3);
    if (is_data) begin
      cur_byte = cmd_r.data[idx_r[3:0]];
      crc_nxt  = lrcf_pkg::crc_byte(crc_in, cur_byte);
    end else begin
      cur_byte = 8'(crc_fin >> {crc_k[1:0], 3'b000});
      crc_nxt  = is_fe ? lrcf_pkg::CRC_INIT : crc_r;
    end
    emit = busy_r && (!out_valid_r || out_ready);
    pop  = cmd_valid && (!busy_r || (emit && is_last));
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      fe_r   <= is_fe;
    end
    if (pop) begin
      cmd_r <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= lrcf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 5'd1;
        if (is_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/led_record_crc_framer.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   mode, channel, type, settings, pixel
// out      output     out_valid / out_ready out_byte, out_last_of_run, out_frame_end
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
// the back end's byte sequencer sends a byte per cycle unless out_ready stalls:
// pixels are 3 or 4 bytes, 4 more on closing the record, a record 10 to 18, a draw 10
// the front end classifies one transaction per cycle while the command queue has room
// a stalled output holds the byte register; the queue lets the front run ahead
// reset is synchronous, active low, and restores the type codes and crc state
module led_record_crc_framer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [7:0]                     in_chan_no,
  input  logic [7:0]                     in_record_type,
  input  logic [7:0]                     in_order_byte,
  input  logic [15:0]                    in_pixel_count,
  input  logic [31:0]                    in_frequency,
  input  logic [7:0]                     in_brightness,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic                           out_last_of_run,
  output logic                           out_frame_end
);

  logic                full, push, pop, q_valid;
  lrcf_pkg::lrcf_cmd_t wr_cmd, rd_cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;

  lrcf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .acc          (in_valid && !full),
    .mode         (in_mode),
    .chan_no      (in_chan_no),
    .record_type  (in_record_type),
    .order_byte   (in_order_byte),
    .pixel_count  (in_pixel_count),
    .frequency    (in_frequency),
    .brightness   (in_brightness),
    .red          (in_red),
    .green        (in_green),
    .blue         (in_blue),
    .push         (push),
    .cmd          (wr_cmd)
  );

  lrcf_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_cmd   (wr_cmd),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  lrcf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd_in          (rd_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_end   (out_frame_end)
  );

endmodule
